// ===== sv/round_robin_task_slot_scheduler_assert.svh =====
// Assertion macros for the round-robin task slot scheduler.
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== sv/rrts_pkg.sv =====
// Shared constants and controller/datapath interface types of the scheduler.
package rrts_pkg;

    // Default number of task slots.
    localparam int SLOTS_DEFAULT = 16;

    // Lowest high-water mark of slots used before a tick may switch tasks.
    localparam int MIN_USED = 2;

    // Action codes of an input item.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_CREATE = 2'd1;
    localparam logic [1:0] ACT_EXIT   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic read_mem;
        logic commit;
    } rrts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic hit;
        logic last;
        logic is_tick;
        logic out_free;
    } rrts_status_t;

endpackage

// ===== sv/round_robin_task_slot_scheduler.sv =====
// Top level of the round-robin task slot scheduler.
//
//   channel   direction  handshake                      payload
//   input     in         in_valid / in_ready            action, saved_stack_pointer,
//                                                       initial_stack_pointer
//   output    out        out_valid / out_ready          switched, previous_slot, next_slot,
//                                                       resume_pointer, create_ok,
//                                                       created_slot, live_count
//   config    in         cfg_write_enable               cfg_write_data (scheduler_enable)
//
// An exit, an unknown action, or a tick that is disabled or whose high-water mark is under two slots,
// goes from load straight to commit. A tick that finds no other runnable slot scans SLOTS - 1 slots.
// A tick that switches scans k slots (k from 1 to SLOTS - 1) and a create k slots
// (k from 1 to SLOTS), where k is the number of slots the scan visits, one per cycle.
// A switching tick then reads the pointer memory before the commit.
// Reset restores slot 0 as the running task with all other slots unused; no clearing pass.
// The result register holds one item; a stalled output holds the next item in commit.
module round_robin_task_slot_scheduler
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] saved_stack_pointer,
    input  logic [31:0] initial_stack_pointer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        switched,
    output logic [3:0]  previous_slot,
    output logic [3:0]  next_slot,
    output logic [31:0] resume_pointer,
    output logic        create_ok,
    output logic [3:0]  created_slot,
    output logic [4:0]  live_count
);

`include "round_robin_task_slot_scheduler_assert.svh"

    rrts_cmd_t    ctrl_cmd;
    rrts_status_t dp_status;

    // Controller.
    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    // Datapath.
    rrts_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_enable      (cfg_write_enable),
        .cfg_write_data        (cfg_write_data),
        .action                (action),
        .saved_stack_pointer   (saved_stack_pointer),
        .initial_stack_pointer (initial_stack_pointer),
        .cmd                   (ctrl_cmd),
        .status                (dp_status),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .switched              (switched),
        .previous_slot         (previous_slot),
        .next_slot             (next_slot),
        .resume_pointer        (resume_pointer),
        .create_ok             (create_ok),
        .created_slot          (created_slot),
        .live_count            (live_count)
    );

    // A commit never overwrites a result that has not been taken.
    `RRTS_ASSERT_NOW(a_commit_free, clk, rst_n, ctrl_cmd.commit, dp_status.out_free)

    // In the cycle after an item is accepted the block is busy.
    `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready), !in_ready)

    // A tick that finds another runnable slot reads its saved pointer next.
    `RRTS_ASSERT_NEXT(a_tick_reads, clk, rst_n,
        (ctrl_cmd.scan_step && dp_status.hit && dp_status.is_tick), ctrl_cmd.read_mem)

    // The controller issues at most one command per cycle.
    `RRTS_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1,
        ($onehot0({ctrl_cmd.load, ctrl_cmd.scan_step, ctrl_cmd.read_mem, ctrl_cmd.commit})))

endmodule

// ===== sv/rrts_ctrl.sv =====
// Controller state machine of the scheduler.
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  rrts_status_t status,
    output rrts_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_COMMIT = 4'b1000
    } rrts_state_t;

    rrts_state_t state_reg;
    rrts_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.need_scan ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit)
                begin
                    state_next = status.is_tick ? ST_READ : ST_COMMIT;
                end
                else if (status.last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_READ:
            begin
                cmd.read_mem = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/rrts_datapath.sv =====
// Datapath of the scheduler: slot table, pointer memory, scan unit and result register.
module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_enable,
    input  logic         cfg_write_data,
    input  logic [1:0]   action,
    input  logic [31:0]  saved_stack_pointer,
    input  logic [31:0]  initial_stack_pointer,
    input  rrts_cmd_t    cmd,
    output rrts_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         switched,
    output logic [3:0]   previous_slot,
    output logic [3:0]   next_slot,
    output logic [31:0]  resume_pointer,
    output logic         create_ok,
    output logic [3:0]   created_slot,
    output logic [4:0]   live_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    // Scheduler state.
    logic              enable_reg;
    logic [SLOTS-1:0]  alive_reg;
    logic [SLOTS-1:0]  alive_next;
    logic [SW-1:0]     cur_reg;
    logic [SW-1:0]     cur_next;
    logic              cur_run_reg;
    logic              cur_run_next;
    logic [LW-1:0]     hw_reg;
    logic [LW-1:0]     hw_next;
    logic [LW-1:0]     live_reg;
    logic [LW-1:0]     live_next;

    // Item and scan registers.
    logic [1:0]        action_reg;
    logic [31:0]       sp_saved_reg;
    logic [31:0]       sp_init_reg;
    logic [SW-1:0]     scan_idx_reg;
    logic [SW-1:0]     scan_cnt_reg;
    logic              found_reg;
    logic [SW-1:0]     found_idx_reg;

    // Pointer memory.
    logic [31:0]       mem [SLOTS];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [SW-1:0]     mem_wa;
    logic [31:0]       mem_wd;

    // Result register.
    logic              out_valid_reg;
    logic              switched_reg;
    logic [3:0]        prev_reg;
    logic [3:0]        next_reg;
    logic [31:0]       resume_reg;
    logic              ok_reg;
    logic [3:0]        created_reg;
    logic [4:0]        live_out_reg;

    logic              is_tick;
    logic              is_create;
    logic              cand_alive;
    logic [SW-1:0]     cur_inc;
    logic [SW-1:0]     scan_inc;

    // Wrapping increments of slot indexes.
    assign cur_inc  = (cur_reg == SW'(SLOTS - 1)) ? '0 : cur_reg + SW'(1);
    assign scan_inc = (scan_idx_reg == SW'(SLOTS - 1)) ? '0 : scan_idx_reg + SW'(1);

    assign is_tick    = (action_reg == ACT_TICK);
    assign is_create  = (action_reg == ACT_CREATE);
    assign cand_alive = alive_reg[scan_idx_reg];

    // Status toward the controller.
    always_comb
    begin
        status.need_scan = ((action == ACT_TICK) && enable_reg && (hw_reg >= LW'(MIN_USED)))
                           || (action == ACT_CREATE);
        status.is_tick   = is_tick;
        status.hit       = is_tick ? cand_alive : !cand_alive;
        status.last      = is_tick ? (scan_cnt_reg == SW'(SLOTS - 2))
                                   : (scan_cnt_reg == SW'(SLOTS - 1));
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            enable_reg <= cfg_write_data;
        end
    end

    // Item capture and scan progress.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg   <= action;
            sp_saved_reg <= saved_stack_pointer;
            sp_init_reg  <= initial_stack_pointer;
            scan_idx_reg <= (action == ACT_TICK) ? cur_inc : '0;
            scan_cnt_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_inc;
            scan_cnt_reg <= scan_cnt_reg + SW'(1);
        end
        if (cmd.scan_step && status.hit)
        begin
            found_idx_reg <= scan_idx_reg;
        end
    end

    // The found flag is control state and is cleared at the start of each item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step && status.hit)
        begin
            found_reg <= 1'b1;
        end
    end

    // Memory port: the outgoing pointer of a running task is saved on a switch, the prepared one on a create.
    assign mem_we = (cmd.read_mem && cur_run_reg) || (cmd.commit && is_create && found_reg);
    assign mem_wa = cmd.read_mem ? cur_reg : found_idx_reg;
    assign mem_wd = cmd.read_mem ? sp_saved_reg : sp_init_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.read_mem)
        begin
            rd_data_reg <= mem[found_idx_reg];
        end
    end

    // Slot table update when the item commits.
    always_comb
    begin
        alive_next   = alive_reg;
        cur_next     = cur_reg;
        cur_run_next = cur_run_reg;
        hw_next      = hw_reg;
        live_next    = live_reg;
        unique case (action_reg)
            ACT_TICK:
            begin
                if (found_reg)
                begin
                    cur_next     = found_idx_reg;
                    cur_run_next = 1'b1;
                end
            end
            ACT_CREATE:
            begin
                if (found_reg)
                begin
                    alive_next[found_idx_reg] = 1'b1;
                    live_next                 = live_reg + LW'(1);
                    if (LW'(found_idx_reg) >= hw_reg)
                    begin
                        hw_next = LW'(found_idx_reg) + LW'(1);
                    end
                    if (found_idx_reg == cur_reg)
                    begin
                        cur_run_next = 1'b0;
                    end
                end
            end
            ACT_EXIT:
            begin
                if (alive_reg[cur_reg])
                begin
                    alive_next[cur_reg] = 1'b0;
                    live_next           = live_reg - LW'(1);
                end
                cur_run_next = 1'b0;
            end
            default:
            begin
                alive_next = alive_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg   <= SLOTS'(1);
            cur_reg     <= '0;
            cur_run_reg <= 1'b1;
            hw_reg      <= LW'(1);
            live_reg    <= LW'(1);
        end
        else if (cmd.commit)
        begin
            alive_reg   <= alive_next;
            cur_reg     <= cur_next;
            cur_run_reg <= cur_run_next;
            hw_reg      <= hw_next;
            live_reg    <= live_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            switched_reg <= is_tick && found_reg;
            prev_reg     <= 4'(cur_reg);
            next_reg     <= 4'(cur_next);
            resume_reg   <= (is_tick && found_reg) ? rd_data_reg : 32'd0;
            ok_reg       <= is_create && found_reg;
            created_reg  <= (is_create && found_reg) ? 4'(found_idx_reg) : 4'd0;
            live_out_reg <= 5'(live_next);
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign switched       = switched_reg;
    assign previous_slot  = prev_reg;
    assign next_slot      = next_reg;
    assign resume_pointer = resume_reg;
    assign create_ok      = ok_reg;
    assign created_slot   = created_reg;
    assign live_count     = live_out_reg;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the round-robin task slot scheduler.
`timescale 1ns / 1ps

module tb;
    import rrts_pkg::*;

    localparam int SLOT_COUNT = SLOTS_DEFAULT;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASE_COUNT = 8;

    typedef enum logic [1:0] {SLOT_DEAD, SLOT_READY, SLOT_RUNNING} slot_state_e;

    typedef struct packed {
        logic        switched;
        logic [3:0]  previous_slot;
        logic [3:0]  next_slot;
        logic [31:0] resume_pointer;
        logic        create_ok;
        logic [3:0]  created_slot;
        logic [4:0]  live_count;
    } sched_result_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        bit            en;
        logic [1:0]    act;
        logic [31:0]   ptr;
        bit            rnd_ptr;
        int            reps;
        bit            typed;
        sched_result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_enable;
    logic        cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] saved_stack_pointer;
    logic [31:0] initial_stack_pointer;
    logic        out_valid;
    logic        out_ready;
    logic        switched;
    logic [3:0]  previous_slot;
    logic [3:0]  next_slot;
    logic [31:0] resume_pointer;
    logic        create_ok;
    logic [3:0]  created_slot;
    logic [4:0]  live_count;

    // Predicted scheduler state.
    slot_state_e slot_st [SLOT_COUNT];
    logic [31:0] slot_ptr [SLOT_COUNT];
    int          cur_slot;
    int          high_water;
    bit          sched_enable;

    sched_result_t pending_results [$];
    dir_row_t      dir_rows [$];
    int            error_count;
    int            quiet_cycles;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_requests;
    int            holds_served;
    int            hold_left;

    round_robin_task_slot_scheduler DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_enable      (cfg_write_enable),
        .cfg_write_data        (cfg_write_data),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .action                (action),
        .saved_stack_pointer   (saved_stack_pointer),
        .initial_stack_pointer (initial_stack_pointer),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .switched              (switched),
        .previous_slot         (previous_slot),
        .next_slot             (next_slot),
        .resume_pointer        (resume_pointer),
        .create_ok             (create_ok),
        .created_slot          (created_slot),
        .live_count            (live_count)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one item to the predicted state and return the result it should produce.
    function automatic sched_result_t schedule_step(logic [1:0] act, logic [31:0] out_sp,
                                                    logic [31:0] init_sp);
        sched_result_t r;
        int prev;
        int nxt;
        int cand;
        int live;
        r = '0;
        prev = cur_slot;
        r.previous_slot = prev[3:0];
        case (act)
            ACT_TICK:
            begin
                if (sched_enable && high_water >= MIN_USED)
                begin
                    nxt = prev;
                    for (int i = 1; i <= SLOT_COUNT; i++)
                    begin
                        cand = (prev + i) % SLOT_COUNT;
                        if (slot_st[cand] != SLOT_DEAD)
                        begin
                            nxt = cand;
                            break;
                        end
                    end
                    if (nxt != prev)
                    begin
                        // Only a running outgoing task gets its pointer saved.
                        if (slot_st[prev] == SLOT_RUNNING)
                        begin
                            slot_ptr[prev] = out_sp;
                            slot_st[prev] = SLOT_READY;
                        end
                        slot_st[nxt] = SLOT_RUNNING;
                        cur_slot = nxt;
                        r.switched = 1'b1;
                        r.resume_pointer = slot_ptr[nxt];
                    end
                end
            end
            ACT_CREATE:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_st[i] == SLOT_DEAD || i >= high_water)
                    begin
                        slot_ptr[i] = init_sp;
                        slot_st[i] = SLOT_READY;
                        if (i >= high_water)
                            high_water = i + 1;
                        r.create_ok = 1'b1;
                        r.created_slot = i[3:0];
                        break;
                    end
                end
            end
            ACT_EXIT:
            begin
                slot_st[prev] = SLOT_DEAD;
            end
            default:
            begin
            end
        endcase
        r.next_slot = cur_slot[3:0];
        live = 0;
        for (int i = 0; i < high_water && i < SLOT_COUNT; i++)
            if (slot_st[i] != SLOT_DEAD)
                live++;
        r.live_count = live[4:0];
        return r;
    endfunction

    function automatic sched_result_t res(logic sw, logic [3:0] prev, logic [3:0] nxt,
                                          logic [31:0] resume, logic ok, logic [3:0] made,
                                          logic [4:0] live);
        return '{sw, prev, nxt, resume, ok, made, live};
    endfunction

    function automatic dir_row_t mk_row(bit en, logic [1:0] act, logic [31:0] ptr, bit rnd,
                                        int reps, bit typed, sched_result_t want);
        dir_row_t row;
        row.en = en;
        row.act = act;
        row.ptr = ptr;
        row.rnd_ptr = rnd;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Offer one item, wait for it to be taken, then record its expected result.
    task automatic offer_item(logic [1:0] act, logic [31:0] out_sp, logic [31:0] init_sp,
                              bit typed, sched_result_t want);
        sched_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        saved_stack_pointer <= out_sp;
        initial_stack_pointer <= init_sp;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = schedule_step(act, out_sp, init_sp);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_enable(bit value);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        sched_enable = value;
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("switched", want.switched, switched);
                check_field("previous_slot", want.previous_slot, previous_slot);
                check_field("next_slot", want.next_slot, next_slot);
                check_field("resume_pointer", want.resume_pointer, resume_pointer);
                check_field("create_ok", want.create_ok, create_ok);
                check_field("created_slot", want.created_slot, created_slot);
                check_field("live_count", want.live_count, live_count);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Stimulus: directed table first, then random phases.
    initial
    begin
        int ph_sender [PHASE_COUNT];
        int ph_stall [PHASE_COUNT];
        bit ph_enable [PHASE_COUNT];
        int ph_create [PHASE_COUNT];
        int ph_exit [PHASE_COUNT];
        logic [31:0] ptr;
        logic [1:0] act;
        int pick;

        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data = 1'b0;
        in_valid = 1'b0;
        action = ACT_TICK;
        saved_stack_pointer = '0;
        initial_stack_pointer = '0;
        out_ready = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;

        // Reset state: slot 0 running, everything else unused.
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_st[i] = SLOT_DEAD;
            slot_ptr[i] = '0;
        end
        slot_st[0] = SLOT_RUNNING;
        cur_slot = 0;
        high_water = 1;
        sched_enable = 1'b0;

        // Directed rows: disabled ticks, single-slot tick, switching both ways,
        // exits including a dead slot, no other runnable slot, a full table and
        // a task re-created while it is still current.
        dir_rows.push_back(mk_row(0, ACT_TICK, 32'h0, 0, 1, 1, res(0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(0, ACT_UNKNOWN, 32'hFFFF_FFFF, 0, 1, 1,
                                  res(0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'hFFFF_FFFF, 0, 1, 1,
                                  res(0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_CREATE, 32'hFFFF_FFFF, 0, 1, 1,
                                  res(0, 0, 0, 0, 1, 1, 2)));
        dir_rows.push_back(mk_row(0, ACT_TICK, 32'h0, 0, 1, 1, res(0, 0, 0, 0, 0, 0, 2)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'hFFFF_FFFF, 0, 1, 1,
                                  res(1, 0, 1, 32'hFFFF_FFFF, 0, 0, 2)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'h0, 0, 1, 1,
                                  res(1, 1, 0, 32'hFFFF_FFFF, 0, 0, 2)));
        dir_rows.push_back(mk_row(1, ACT_EXIT, 32'h0, 0, 1, 1, res(0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_EXIT, 32'h0, 0, 1, 1, res(0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'h1234_5678, 0, 1, 1,
                                  res(1, 0, 1, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'h0, 0, 1, 1, res(0, 1, 1, 0, 0, 0, 1)));
        dir_rows.push_back(mk_row(1, ACT_CREATE, 32'h0, 0, 1, 1, res(0, 1, 1, 0, 1, 0, 2)));
        dir_rows.push_back(mk_row(1, ACT_CREATE, 32'h0, 1, 14, 0, '0));
        dir_rows.push_back(mk_row(1, ACT_CREATE, 32'hFFFF_FFFF, 0, 1, 1,
                                  res(0, 1, 1, 0, 0, 0, 16)));
        dir_rows.push_back(mk_row(1, ACT_EXIT, 32'h0, 0, 1, 1, res(0, 1, 1, 0, 0, 0, 15)));
        dir_rows.push_back(mk_row(1, ACT_CREATE, 32'h5A5A_5A5A, 0, 1, 1,
                                  res(0, 1, 1, 0, 1, 1, 16)));
        dir_rows.push_back(mk_row(1, ACT_TICK, 32'h0, 1, 4, 0, '0));
        dir_rows.push_back(mk_row(1, ACT_UNKNOWN, 32'h0, 1, 1, 0, '0));
        dir_rows.push_back(mk_row(1, ACT_EXIT, 32'h0, 1, 1, 0, '0));

        // Random phases: sender idle, receiver stall, enable, create and exit shares.
        ph_sender = '{0, 67, 0, 16, 0, 16, 0, 67};
        ph_stall  = '{0, 0, 67, 16, 0, 16, 67, 0};
        ph_enable = '{1, 1, 1, 1, 0, 1, 1, 1};
        ph_create = '{30, 45, 20, 30, 30, 30, 45, 25};
        ph_exit   = '{15, 10, 30, 20, 20, 15, 10, 25};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_enable(1'b0);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].en != sched_enable)
            begin
                wait_idle();
                write_enable(dir_rows[k].en);
            end
            for (int n = 0; n < dir_rows[k].reps; n++)
            begin
                ptr = dir_rows[k].rnd_ptr ? $urandom() : dir_rows[k].ptr;
                offer_item(dir_rows[k].act, ptr, ptr, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_enable(ph_enable[p]);
            sender_idle_pct = ph_sender[p];
            receiver_stall_pct = ph_stall[p];
            // In the pressure phase the receiver holds off while items keep coming.
            if (p == 5)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    act = ACT_UNKNOWN;
                else if (pick < 3 + ph_create[p])
                    act = ACT_CREATE;
                else if (pick < 3 + ph_create[p] + ph_exit[p])
                    act = ACT_EXIT;
                else
                    act = ACT_TICK;
                offer_item(act, $urandom(), $urandom(), 0, '0);
            end
        end

        // Drain and give the block time to show any stray result.
        wait_idle();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
